FILE: hdl/hill_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the streaming Hill cipher encryptor.
// No dependencies; imported by hill_cipher_encrypt, hill_chk and the testbench.
package hill_pkg;

    // Field widths fixed by the interface
    localparam int BYTE_W     = 8;
    localparam int SIZE_W     = 3;
    localparam int ROW_W      = 40;
    localparam int VALUE_W    = 19;
    localparam int PROD_W     = 2 * BYTE_W;
    localparam int CFG_IDX_W  = 3;

    // Key matrix storage: five rows of five bytes
    localparam int KEY_ROWS   = 5;
    localparam int KEY_COLS   = 5;

    // Default largest block length
    localparam int DEF_MAX_KEY_SIZE = 5;

    // Largest possible dot product: 5 * 255 * 255
    localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(325125);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_4 = 3'd5;

    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [BYTE_W-1:0] t_byte;

    // Descriptor of a closed block waiting in or leaving the buffer memory
    typedef struct packed {
        logic  bank;
        t_size fill;   // bytes actually received; the rest reads as zero
        t_size len;    // block length N at the time of closing
        logic  last;   // closed by a byte marked last
    } t_blk_desc;

endpackage

FILE: hdl/hill_cipher_encrypt.sv
`timescale 1ns / 1ps
// Streaming Hill cipher encryptor: block gathering, key matrix product.
// Depends on hill_pkg.
//
// Message bytes are written one per cycle while o_in_ready is high into a
// two-bank block memory; a block of N bytes (N = key_size, clamped to
// 1..min(MAX_KEY_SIZE,5)) closes when full or at a byte marked last, and zero
// padding is applied on the read side. A closed block is read out of its bank
// into a holding register, then, with the output ready, one column product per
// cycle goes through a product stage and a sum stage into the output register:
// N values per block. Sustained rate with the output ready is one byte in and
// one value out per cycle; the limit is the single holding register, which
// works one column a cycle, so a block closed early by a last byte is taken
// only once the previously closed block has moved out of its memory bank.
// Key and size registers may be rewritten whenever no results are pending.
module hill_cipher_encrypt #(
    parameter int MAX_KEY_SIZE = hill_pkg::DEF_MAX_KEY_SIZE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [hill_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hill_pkg::ROW_W-1:0]    i_cfg_data,
    // message byte channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [hill_pkg::BYTE_W-1:0]   i_msg_byte,
    input  logic                          i_msg_last,
    // cipher value channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [hill_pkg::VALUE_W-1:0]  o_cipher_value,
    output logic                          o_out_last
);
    import hill_pkg::*;

    // Usable block length and memory lane index width
    localparam int LIM   = (MAX_KEY_SIZE < KEY_ROWS) ? MAX_KEY_SIZE : KEY_ROWS;
    localparam int POS_W = $clog2(LIM);

    typedef logic [LIM-1:0][BYTE_W-1:0] t_block;

    // Configuration registers
    t_size                 r_key_size;
    logic [ROW_W-1:0]      r_key_row [KEY_ROWS];

    // Block memory: two banks, one byte lane per block position
    t_block                r_mem [2];

    // Writer side
    t_size                 r_fill;
    logic                  r_wr_bank;
    t_size                 blk_len;
    t_size                 wr_pos;
    t_size                 fill_new;
    logic                  closes;
    logic                  in_fire;

    // Closed block waiting in memory
    logic                  r_pend_v;
    t_blk_desc             r_pend;
    t_blk_desc             n_pend;
    logic                  pend_rd;

    // Holding register fed by the memory read port
    logic                  r_blk_v;
    t_block                r_blk_data;
    t_blk_desc             r_blk;
    t_size                 r_col;
    logic                  col_end;

    // Product and sum stages
    logic                  ce;
    logic                  r_prod_v;
    logic                  r_prod_last;
    logic [PROD_W-1:0]     r_prod [LIM];
    logic [VALUE_W-1:0]    prod_sum;
    logic                  r_out_v;
    logic [VALUE_W-1:0]    r_out_value;
    logic                  r_out_last;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size <= t_size'(1);
            for (int i = 0; i < KEY_ROWS; i++) begin
                r_key_row[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index) inside
                CFG_KEY_SIZE: begin
                    r_key_size <= i_cfg_data[SIZE_W-1:0];
                end
                [CFG_KEY_ROW_0:CFG_KEY_ROW_4]: begin
                    r_key_row[i_cfg_index - CFG_KEY_ROW_0] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Block length: zero acts as one, large values saturate
    always_comb begin
        if (r_key_size == '0) begin
            blk_len = t_size'(1);
        end else if (r_key_size > t_size'(LIM)) begin
            blk_len = t_size'(LIM);
        end else begin
            blk_len = r_key_size;
        end
    end

    // Write position clamps to the last slot if the size shrank mid-block
    assign wr_pos   = (r_fill >= blk_len) ? blk_len - t_size'(1) : r_fill;
    assign fill_new = wr_pos + t_size'(1);
    assign closes   = (fill_new == blk_len) || i_msg_last;

    // Holding register frees when its last column enters the product stage
    assign ce       = !r_out_v || i_out_ready;
    assign col_end  = (r_col == r_blk.len - t_size'(1));
    assign pend_rd  = r_pend_v && (!r_blk_v || (ce && col_end));

    // A closing byte needs the pending slot free (or emptying this cycle)
    assign o_in_ready = !r_pend_v || pend_rd || !closes;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_pend.bank = r_wr_bank;
        n_pend.fill = fill_new;
        n_pend.len  = blk_len;
        n_pend.last = i_msg_last;
    end

    // Block memory write and read; the bank being read is never the one
    // being filled, and a closed bank is read no earlier than the cycle after
    // its final write, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mem[r_wr_bank][wr_pos[POS_W-1:0]] <= i_msg_byte;
        end
        if (pend_rd) begin
            r_blk_data <= r_mem[r_pend.bank];
        end
    end

    // Writer fill count and bank select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_wr_bank <= 1'b0;
        end else if (in_fire) begin
            if (closes) begin
                r_fill    <= '0;
                r_wr_bank <= !r_wr_bank;
            end else begin
                r_fill    <= fill_new;
            end
        end
    end

    // Pending closed block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (in_fire && closes) begin
            r_pend_v <= 1'b1;
        end else if (pend_rd) begin
            r_pend_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && closes) begin
            r_pend <= n_pend;
        end
    end

    // Holding register control and column counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_v <= 1'b0;
            r_col   <= '0;
        end else if (pend_rd) begin
            r_blk_v <= 1'b1;
            r_col   <= '0;
        end else if (ce && r_blk_v) begin
            if (col_end) begin
                r_blk_v <= 1'b0;
                r_col   <= '0;
            end else begin
                r_col   <= r_col + t_size'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_rd) begin
            r_blk <= r_pend;
        end
    end

    // Product stage: padded byte times key entry for the current column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else if (ce) begin
            r_prod_v <= r_blk_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_prod_last <= r_blk.last && col_end;
            for (int i = 0; i < LIM; i++) begin
                if (t_size'(i) < r_blk.fill) begin
                    r_prod[i] <= PROD_W'(r_blk_data[i])
                               * PROD_W'(r_key_row[i][r_col*BYTE_W +: BYTE_W]);
                end else begin
                    r_prod[i] <= '0;
                end
            end
        end
    end

    // Sum stage into the output register
    always_comb begin
        prod_sum = '0;
        for (int i = 0; i < LIM; i++) begin
            prod_sum = prod_sum + VALUE_W'(r_prod[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (ce) begin
            r_out_v <= r_prod_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out_value <= prod_sum;
            r_out_last  <= r_prod_last;
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_cipher_value = r_out_value;
    assign o_out_last     = r_out_last;

endmodule

FILE: hdl/hill_chk.sv
`timescale 1ns / 1ps
// Port-level checks for hill_cipher_encrypt, attached by bind.
// Depends on hill_pkg and hill_cipher_encrypt.
module hill_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [hill_pkg::VALUE_W-1:0]  o_cipher_value,
    input logic                          o_out_last
);
    import hill_pkg::*;

    // A stalled result holds its value and last flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_cipher_value) && $stable(o_out_last))
        else $error("stalled result changed or dropped");

    // A dot product of five bytes by five bytes cannot exceed its bound
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cipher_value <= VALUE_MAX)
        else $error("cipher value above the largest possible product sum");

    // Reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind hill_cipher_encrypt hill_chk u_hill_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_cipher_value (o_cipher_value),
    .o_out_last     (o_out_last)
);

FILE: test/hill_cipher_encrypt_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for hill_cipher_encrypt: scoreboard class plus stimulus tasks.
// Depends on hill_pkg and the hill_cipher_encrypt RTL; no files or arguments.
module hill_cipher_encrypt_test;
    import hill_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 420;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int HOLD_CYCLES   = 1000;
    localparam int HOLD_MSGS     = 6;

    // Indexes past the last key row; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = CFG_KEY_ROW_4 + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = CFG_KEY_ROW_4 + 3'd2;
    localparam logic [ROW_W-1:0]     ROW_ALL_ONES    = '1;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_cipher_word;

    // Scoreboard: mirrors the key registers and the open block, and holds
    // the cipher values still owed by the DUT.
    class cipher_scoreboard;
        logic [SIZE_W-1:0] key_size;
        logic [ROW_W-1:0]  key_rows[KEY_ROWS];
        t_byte             block_bytes[KEY_COLS];
        int unsigned       fill;
        t_cipher_word      owed_words[$];
        int unsigned       errors;
        int unsigned       bytes_seen;
        int unsigned       words_seen;

        function new();
            key_size = SIZE_W'(1);
            foreach (key_rows[i]) key_rows[i] = '0;
            foreach (block_bytes[i]) block_bytes[i] = '0;
            fill       = 0;
            errors     = 0;
            bytes_seen = 0;
            words_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
            if (idx == CFG_KEY_SIZE)
                key_size = data[SIZE_W-1:0];
            else if (idx >= CFG_KEY_ROW_0 && idx <= CFG_KEY_ROW_4)
                key_rows[idx - CFG_KEY_ROW_0] = data;
        endfunction

        // Effective block length: zero reads as one, large values saturate
        function int unsigned block_len();
            int unsigned lim;
            int unsigned n;
            lim = (DEF_MAX_KEY_SIZE < KEY_ROWS) ? DEF_MAX_KEY_SIZE : KEY_ROWS;
            n = key_size;
            if (n < 1) n = 1;
            if (n > lim) n = lim;
            return n;
        endfunction

        function int unsigned pending();
            return owed_words.size();
        endfunction

        // One accepted message byte; closes the block when full or marked last
        function void note_byte(t_byte b, logic last);
            int unsigned n;
            int unsigned pos;
            int unsigned sum;
            t_cipher_word w;
            bytes_seen++;
            n   = block_len();
            pos = (fill >= n) ? n - 1 : fill;
            block_bytes[pos] = b;
            fill = pos + 1;
            if (fill < n && !last) return;
            for (int i = fill; i < n; i++) block_bytes[i] = '0;
            for (int j = 0; j < n; j++) begin
                sum = 0;
                for (int i = 0; i < n; i++)
                    sum += int'(block_bytes[i]) * int'(key_rows[i][8*j +: 8]);
                w.value = VALUE_W'(sum);
                w.last  = last && (j == n - 1);
                owed_words.push_back(w);
            end
            fill = 0;
        endfunction

        task flag_mismatch(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task check_word(logic [VALUE_W-1:0] value, logic last);
            t_cipher_word w;
            words_seen++;
            if (owed_words.size() == 0) begin
                flag_mismatch($sformatf("unexpected value %0d last %0b", value, last));
                return;
            end
            w = owed_words.pop_front();
            if (value !== w.value)
                flag_mismatch($sformatf("value %0d, want %0d", value, w.value));
            if (last !== w.last)
                flag_mismatch($sformatf("last %0b, want %0b (value %0d)", last, w.last, w.value));
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [ROW_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [BYTE_W-1:0]    i_msg_byte;
    logic                 i_msg_last;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [VALUE_W-1:0]   o_cipher_value;
    logic                 o_out_last;

    cipher_scoreboard sb = new();
    int unsigned      burst_left    = 0;
    int unsigned      hold_request  = 0;
    int unsigned      cfg_writes    = 0;
    int unsigned      idle_count    = 0;

    hill_cipher_encrypt u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_msg_byte     (i_msg_byte),
        .i_msg_last     (i_msg_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cipher_value (o_cipher_value),
        .o_out_last     (o_out_last)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Transaction monitors on both channels
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_byte(i_msg_byte, i_msg_last);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_word(o_cipher_value, o_out_last);
    end

    // Watchdog: too long without any transaction ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_MAX) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_MAX);
            $display("hill_cipher_encrypt verification failed");
            $finish;
        end
    end

    // Receiver: ready pattern changes mode after each random span; a hold
    // request drops ready for a long stretch
    initial begin
        int unsigned mode;
        int unsigned span;
        int unsigned hold_left;
        mode        = 0;
        span        = 0;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(16, 120);
                end
                span--;
                case (mode)
                    0: i_out_ready = 1'b1;
                    1: i_out_ready = ($urandom_range(0, 1) == 0);
                    2: i_out_ready = ($urandom_range(0, 3) == 0);
                    default: i_out_ready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // One message byte; sender idles between bursts of random length
    task automatic push_byte(input t_byte b, input logic last);
        int unsigned gap;
        int unsigned r;
        if (burst_left == 0) begin
            r = $urandom_range(0, 7);
            if (r < 2)      gap = 0;
            else if (r < 6) gap = $urandom_range(1, 4);
            else            gap = $urandom_range(5, 20);
            if (gap != 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid = 1'b1;
        i_msg_byte = b;
        i_msg_last = last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Wait until every owed value is out and the pipeline has gone quiet
    task automatic settle();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.write_reg(idx, data);
        cfg_writes++;
    endtask

    function automatic logic [ROW_W-1:0] rand_row();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = $urandom;
        hi = $urandom;
        case ($urandom_range(0, 7))
            0:       return ROW_ALL_ONES;
            1:       return '0;
            default: return {hi[7:0], lo};
        endcase
    endfunction

    function automatic t_byte rand_byte();
        case ($urandom_range(0, 9))
            0:       return 8'hFF;
            1:       return 8'h00;
            default: return t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic load_key(input logic [SIZE_W-1:0] n);
        write_reg(CFG_KEY_SIZE, ROW_W'(n));
        for (int r = 0; r < KEY_ROWS; r++)
            write_reg(CFG_KEY_ROW_0 + CFG_IDX_W'(r), rand_row());
    endtask

    initial begin
        int unsigned rand_items;
        int unsigned msgs;
        int unsigned len;
        int unsigned r;
        logic [SIZE_W-1:0] n;
        logic open_tail;
        logic hold_done;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_msg_byte  = '0;
        i_msg_last  = 1'b0;
        rand_items  = 0;
        hold_done   = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Largest block with all-ones key: every sum at its maximum,
        // then a single zero byte marked last
        write_reg(CFG_KEY_SIZE, ROW_W'(5));
        for (int k = 0; k < KEY_ROWS; k++)
            write_reg(CFG_KEY_ROW_0 + CFG_IDX_W'(k), ROW_ALL_ONES);
        repeat (5) push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);

        // Key size zero behaves as one
        settle();
        load_key(3'd0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b1);

        // Oversized key size saturates; writes to unmapped indexes are dropped
        settle();
        load_key(3'd7);
        write_reg(CFG_UNMAPPED_LO, ROW_ALL_ONES);
        write_reg(CFG_UNMAPPED_HI, rand_row());
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h01, 1'b1);

        // Key size shrunk under an open block: next byte overwrites the
        // last slot and closes the block
        settle();
        load_key(3'd5);
        repeat (3) push_byte(rand_byte(), 1'b0);
        settle();
        write_reg(CFG_KEY_SIZE, ROW_W'(2));
        push_byte(8'hC3, 1'b0);

        // Size one, then size four with junk outside the used corner
        settle();
        load_key(3'd1);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b1);
        settle();
        load_key(3'd4);
        repeat (4) push_byte(rand_byte(), 1'b0);
        push_byte(8'hFE, 1'b0);
        push_byte(8'h3C, 1'b1);

        // Random phases: new key, a handful of messages, sometimes an open tail
        while (rand_items < RANDOM_ITEMS) begin
            settle();
            r = $urandom_range(0, 9);
            case (r)
                0:       n = 3'd0;
                1:       n = 3'd6;
                2:       n = 3'd7;
                default: n = SIZE_W'($urandom_range(1, 5));
            endcase
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_KEY_SIZE, ROW_W'(n));
            end else begin
                load_key(n);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI, rand_row());
            // Long output stall; enough closing messages to back up into the input
            if (!hold_done && rand_items > 150) begin
                hold_request = HOLD_CYCLES;
                hold_done    = 1'b1;
                msgs         = HOLD_MSGS;
            end else begin
                msgs = $urandom_range(2, 6);
            end
            for (int m = 0; m < msgs; m++) begin
                len       = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 30)
                                                        : $urandom_range(1, 12);
                open_tail = (m == msgs - 1) && ($urandom_range(0, 3) == 0);
                for (int k = 0; k < len; k++) begin
                    push_byte(rand_byte(), (k == len - 1) && !open_tail);
                    rand_items++;
                end
            end
        end

        // Drain what is owed, then watch for stray values
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.pending() != 0)
            sb.flag_mismatch($sformatf("%0d values never arrived", sb.pending()));

        $display("covered %0d message bytes and %0d cipher values over %0d register writes,",
                 sb.bytes_seen, sb.words_seen, cfg_writes);
        $display("key sizes 0 through 7, partial and shrunk blocks, long output stall");
        if (sb.errors == 0) begin
            $display("hill_cipher_encrypt verification clean");
        end else begin
            $display("hill_cipher_encrypt verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/hill_pkg.sv
hdl/hill_cipher_encrypt.sv
hdl/hill_chk.sv
test/hill_cipher_encrypt_test.sv
